[hw/rtl/arp_pkg.sv]
// ----------------------------------------------------------------------------
// ARP responder package
// Shared types, register indexes and frame constants.
// ----------------------------------------------------------------------------
package arp_pkg;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       rx_last;
    } t_rx_item;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       tx_last;
    } t_tx_item;

    typedef struct packed {
        logic [47:0] peer_mac;
        logic [31:0] peer_ip;
        logic [47:0] echo_hdr;
    } t_reply_desc;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_OWN_MAC = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_OWN_IP  = 1'b1;
    localparam int CFG_DATA_W = 48;

    localparam logic [15:0] ETHERTYPE_ARP = 16'h0806;
    localparam logic [15:0] OP_REQUEST    = 16'h0001;
    localparam logic [15:0] OP_REPLY      = 16'h0002;

    localparam int POS_W = 6;
    localparam int REPLY_LEN = 42;
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(REPLY_LEN - 1);
    localparam logic [POS_W-1:0] POS_MAX  = '1;

    localparam int QUEUE_DEPTH = 2;

endpackage

[hw/rtl/arp_rx_parse.sv]
// ----------------------------------------------------------------------------
// ARP receive parser
// Checks the EtherType, opcode and target IP bytes against the request pattern,
// captures the sender fields and raises a reply descriptor on a qualifying last byte.
// ----------------------------------------------------------------------------
module arp_rx_parse (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  arp_pkg::t_rx_item    i_rx,
    input  logic [31:0]          i_own_ip,
    output logic                 o_push,
    output arp_pkg::t_reply_desc o_desc
);
    import arp_pkg::*;

    logic [POS_W-1:0] r_pos;
    logic             r_ok;
    logic [47:0]      r_echo;
    logic [47:0]      r_peer_mac;
    logic [31:0]      r_peer_ip;

    logic [7:0]       b;
    logic [1:0]       ip_sel;
    logic [7:0]       ip_byte;
    logic             fail;
    logic             n_ok;
    logic [POS_W-1:0] n_pos;

    always_comb begin
        b      = i_rx.rx_byte;
        ip_sel = 2'(r_pos - 6'd38);
        case (ip_sel)
            2'd0:    ip_byte = i_own_ip[31:24];
            2'd1:    ip_byte = i_own_ip[23:16];
            2'd2:    ip_byte = i_own_ip[15:8];
            default: ip_byte = i_own_ip[7:0];
        endcase
        fail = (r_pos == 6'd12 && b != ETHERTYPE_ARP[15:8])
            || (r_pos == 6'd13 && b != ETHERTYPE_ARP[7:0])
            || (r_pos == 6'd20 && b != OP_REQUEST[15:8])
            || (r_pos == 6'd21 && b != OP_REQUEST[7:0])
            || (r_pos >= 6'd38 && r_pos <= POS_LAST && b != ip_byte);
        n_ok   = r_ok && !fail;
        n_pos  = (r_pos == POS_MAX) ? r_pos : r_pos + 1'b1;
        o_push = i_accept && i_rx.rx_last && n_ok && (r_pos >= POS_LAST);
        o_desc = '{peer_mac: r_peer_mac, peer_ip: r_peer_ip, echo_hdr: r_echo};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_ok  <= 1'b1;
        end else if (i_accept) begin
            if (i_rx.rx_last) begin
                r_pos <= '0;
                r_ok  <= 1'b1;
            end else begin
                r_pos <= n_pos;
                r_ok  <= n_ok;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && r_pos >= 6'd14 && r_pos <= 6'd19) begin
            r_echo <= {r_echo[39:0], b};
        end
        if (i_accept && r_pos >= 6'd22 && r_pos <= 6'd27) begin
            r_peer_mac <= {r_peer_mac[39:0], b};
        end
        if (i_accept && r_pos >= 6'd28 && r_pos <= 6'd31) begin
            r_peer_ip <= {r_peer_ip[23:0], b};
        end
    end

    a_push_long_enough: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (r_pos >= POS_LAST))
        else $error("reply raised before byte 41");

endmodule

[hw/rtl/arp_desc_fifo.sv]
// ----------------------------------------------------------------------------
// ARP reply descriptor queue
// Short queue between the receive parser and the reply generator.
// ----------------------------------------------------------------------------
module arp_desc_fifo #(
    parameter int DEPTH = arp_pkg::QUEUE_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  arp_pkg::t_reply_desc i_data,
    input  logic                 i_pop,
    output arp_pkg::t_reply_desc o_data,
    output logic                 o_full,
    output logic                 o_empty
);
    import arp_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_reply_desc     r_mem [DEPTH];
    logic [AW-1:0]   r_wr;
    logic [AW-1:0]   r_rd;
    logic [CW-1:0]   r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop))
        else $error("descriptor queue overflow");

endmodule

[hw/rtl/arp_tx_gen.sv]
// ----------------------------------------------------------------------------
// ARP reply generator
// Takes reply descriptors and streams each 42-byte reply through an output
// register.
// ----------------------------------------------------------------------------
module arp_tx_gen (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  arp_pkg::t_reply_desc i_desc,
    input  logic                 i_empty,
    output logic                 o_pop,
    input  logic [47:0]          i_own_mac,
    input  logic [31:0]          i_own_ip,
    output logic                 o_tx_valid,
    input  logic                 i_tx_stall,
    output arp_pkg::t_tx_item    o_tx
);
    import arp_pkg::*;

    logic             r_active;
    logic [POS_W-1:0] r_idx;
    t_reply_desc      r_desc;
    logic             r_tx_valid;
    t_tx_item         r_tx;

    logic             adv;
    logic             at_end;
    logic             load;
    logic [REPLY_LEN*8-1:0] frame;
    logic [POS_W-1:0] sel;
    logic [7:0]       cur_byte;

    always_comb begin
        adv    = !r_tx_valid || !i_tx_stall;
        at_end = (r_idx == POS_LAST);
        load   = adv && !i_empty && (!r_active || at_end);
        frame  = {r_desc.peer_mac, i_own_mac, ETHERTYPE_ARP, r_desc.echo_hdr,
                  OP_REPLY, i_own_mac, i_own_ip, r_desc.peer_mac, r_desc.peer_ip};
        sel      = POS_LAST - r_idx;
        cur_byte = frame[{sel, 3'b000} +: 8];
    end

    assign o_pop      = load;
    assign o_tx_valid = r_tx_valid;
    assign o_tx       = r_tx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= 1'b0;
            r_idx      <= '0;
            r_tx_valid <= 1'b0;
        end else if (adv) begin
            r_tx_valid <= r_active;
            if (load) begin
                r_active <= 1'b1;
                r_idx    <= '0;
            end else if (r_active && at_end) begin
                r_active <= 1'b0;
                r_idx    <= '0;
            end else if (r_active) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_active) begin
            r_tx.tx_byte <= cur_byte;
            r_tx.tx_last <= at_end;
        end
        if (load) begin
            r_desc <= i_desc;
        end
    end

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= POS_LAST)
        else $error("reply byte index out of range");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> !i_empty)
        else $error("pop from empty descriptor queue");

    a_last_ends_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_active && at_end && !load) |=> !r_active)
        else $error("reply did not end after its last byte");

endmodule

[hw/rtl/arp_request_responder.sv]
// ----------------------------------------------------------------------------
// ARP request responder
// Answers ARP requests for this station's IPv4 address with a reply frame.
// ----------------------------------------------------------------------------
// Usage:
//   Receive channel (i_rx_valid / o_rx_stall / i_rx) carries one frame byte
//   per transfer, rx_last on the final byte, one byte per cycle when not stalled.
//   Transmit channel (o_tx_valid / i_tx_stall / o_tx) carries the 42-byte
//   reply, tx_last on the final byte, one byte per cycle when not stalled.
//   Configuration channel (i_cfg_valid / o_cfg_ready) writes own_mac
//   (index 0) or own_ip (index 1, data bits 31:0); write only while idle.
//   After the request's last byte, its descriptor passes the queue and the
//   generator's active state to the output register; the reply then runs at
//   one byte per cycle when not stalled, and a queued reply follows with no gap.
//   Replies wait in a descriptor queue of QUEUE_DEPTH entries; o_rx_stall
//   rises only while that queue is full, so receive stalls only once the
//   transmit side is held off long enough for QUEUE_DEPTH replies to wait behind
//   the one being sent.
//   Reset clears the parser, queue and generator; own_mac and own_ip
//   return to zero. A stalled output byte holds until it is transferred.
// ----------------------------------------------------------------------------
module arp_request_responder #(
    parameter int QUEUE_DEPTH = arp_pkg::QUEUE_DEPTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_rx_valid,
    output logic                             o_rx_stall,
    input  arp_pkg::t_rx_item                i_rx,
    output logic                             o_tx_valid,
    input  logic                             i_tx_stall,
    output arp_pkg::t_tx_item                o_tx,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [arp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [arp_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import arp_pkg::*;

    logic [47:0] r_own_mac;
    logic [31:0] r_own_ip;

    logic        rx_accept;
    logic        push;
    logic        pop;
    logic        q_full;
    logic        q_empty;
    t_reply_desc push_desc;
    t_reply_desc pop_desc;

    assign o_cfg_ready = 1'b1;
    assign o_rx_stall  = q_full;
    assign rx_accept   = i_rx_valid && !o_rx_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_mac <= '0;
            r_own_ip  <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_OWN_MAC: r_own_mac <= i_cfg_data[47:0];
                REG_OWN_IP:  r_own_ip  <= i_cfg_data[31:0];
                default:     r_own_ip  <= r_own_ip;
            endcase
        end
    end

    arp_rx_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (rx_accept),
        .i_rx     (i_rx),
        .i_own_ip (r_own_ip),
        .o_push   (push),
        .o_desc   (push_desc)
    );

    arp_desc_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_desc),
        .i_pop   (pop),
        .o_data  (pop_desc),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    arp_tx_gen u_gen (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_desc     (pop_desc),
        .i_empty    (q_empty),
        .o_pop      (pop),
        .i_own_mac  (r_own_mac),
        .i_own_ip   (r_own_ip),
        .o_tx_valid (o_tx_valid),
        .i_tx_stall (i_tx_stall),
        .o_tx       (o_tx)
    );

endmodule
